FILE: rtl/core/wav_pkg.sv
package wav_pkg;

    // window store geometry
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // field widths
    localparam int POS_W  = 16;
    localparam int TIME_W = 16;
    localparam int TOT_W  = TIME_W + 1;
    localparam int FRAC_W = 16;
    localparam int QUO_W  = POS_W + FRAC_W;
    localparam int SPD_W  = QUO_W + 1;
    localparam int ENT_W  = 7;
    localparam int STEP_W = $clog2(QUO_W);

    localparam logic [TIME_W-1:0] SPAN_RESET = TIME_W'(1000);

    // command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // one stored sample
    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [TIME_W-1:0] t;
    } t_sample;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EVICT,
        S_WRITE,
        S_TRIM_CHK,
        S_TRIM_SUB,
        S_LOAD_OLD,
        S_LOAD_NEW,
        S_DIVIDE,
        S_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_clear;
        logic set_evict;
        logic drop_oldest;
        logic write_sample;
        logic rd_newest;
        logic cap_old;
        logic start_div;
        logic upd_speed;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_clear;
        logic full;
        logic trim_need;
        logic calc_ok;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/core/wav_ifs.sv
interface wav_in_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic signed [wav_pkg::POS_W-1:0]  pos_x;
    logic signed [wav_pkg::POS_W-1:0]  pos_y;
    logic        [wav_pkg::TIME_W-1:0] elapsed_ms;

    modport source (output valid, command, pos_x, pos_y, elapsed_ms, input ready);
    modport sink   (input valid, command, pos_x, pos_y, elapsed_ms, output ready);
endinterface

interface wav_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [wav_pkg::SPD_W-1:0]  speed_x;
    logic signed [wav_pkg::SPD_W-1:0]  speed_y;
    logic        [wav_pkg::TIME_W-1:0] window_time;
    logic        [wav_pkg::ENT_W-1:0]  window_entries;
    logic                              evicted_full;

    modport source (output valid, speed_x, speed_y, window_time, window_entries,
                    evicted_full, input ready);
    modport sink   (input valid, speed_x, speed_y, window_time, window_entries,
                    evicted_full, output ready);
endinterface

FILE: rtl/core/wav_div.sv
module wav_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wav_pkg::QUO_W-1:0]  i_dividend,
    input  logic [wav_pkg::TOT_W-1:0]  i_divisor,
    output logic [wav_pkg::QUO_W-1:0]  o_quot,
    output logic                       o_done
);

    logic                        r_busy;
    logic                        r_done;
    logic [wav_pkg::STEP_W-1:0]  r_cnt;
    logic [wav_pkg::TOT_W-1:0]   r_rem;
    logic [wav_pkg::QUO_W-1:0]   r_quo;
    logic [wav_pkg::TOT_W-1:0]   r_den;

    logic [wav_pkg::TOT_W:0]     w_shift;
    logic [wav_pkg::TOT_W:0]     w_trial;
    logic                        w_bit;
    logic [wav_pkg::TOT_W-1:0]   n_rem;

    // one restoring step: shift in next dividend bit, try subtract
    always_comb begin
        w_shift = {r_rem, r_quo[wav_pkg::QUO_W-1]};
        w_trial = w_shift - {1'b0, r_den};
        w_bit   = (w_shift >= {1'b0, r_den});
        n_rem   = w_bit ? w_trial[wav_pkg::TOT_W-1:0] : w_shift[wav_pkg::TOT_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // remainder, quotient and step count
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= wav_pkg::STEP_W'(wav_pkg::QUO_W - 1);
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= n_rem;
            r_quo <= {r_quo[wav_pkg::QUO_W-2:0], w_bit};
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

endmodule

FILE: rtl/core/wav_ctrl.sv
module wav_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  wav_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output wav_pkg::t_cmd  o_cmd
);

    wav_pkg::t_state r_state;
    wav_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wav_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wav_pkg::S_IDLE: begin
                if (i_in_valid) n_state = wav_pkg::S_DECODE;
            end
            wav_pkg::S_DECODE: begin
                if (i_stat.is_clear) n_state = wav_pkg::S_RESULT;
                else if (i_stat.full) n_state = wav_pkg::S_EVICT;
                else n_state = wav_pkg::S_WRITE;
            end
            wav_pkg::S_EVICT:    n_state = wav_pkg::S_WRITE;
            wav_pkg::S_WRITE:    n_state = wav_pkg::S_TRIM_CHK;
            wav_pkg::S_TRIM_CHK: begin
                if (i_stat.trim_need) n_state = wav_pkg::S_TRIM_SUB;
                else if (i_stat.calc_ok) n_state = wav_pkg::S_LOAD_OLD;
                else n_state = wav_pkg::S_RESULT;
            end
            wav_pkg::S_TRIM_SUB: n_state = wav_pkg::S_TRIM_CHK;
            wav_pkg::S_LOAD_OLD: n_state = wav_pkg::S_LOAD_NEW;
            wav_pkg::S_LOAD_NEW: n_state = wav_pkg::S_DIVIDE;
            wav_pkg::S_DIVIDE: begin
                if (i_stat.div_done) n_state = wav_pkg::S_RESULT;
            end
            wav_pkg::S_RESULT: begin
                if (i_stat.out_free) n_state = wav_pkg::S_IDLE;
            end
            default: n_state = wav_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            wav_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            wav_pkg::S_DECODE:   o_cmd.do_clear = i_stat.is_clear;
            wav_pkg::S_EVICT: begin
                o_cmd.drop_oldest = 1'b1;
                o_cmd.set_evict   = 1'b1;
            end
            wav_pkg::S_WRITE:    o_cmd.write_sample = 1'b1;
            wav_pkg::S_TRIM_CHK: begin
            end
            wav_pkg::S_TRIM_SUB: o_cmd.drop_oldest = 1'b1;
            wav_pkg::S_LOAD_OLD: begin
                o_cmd.cap_old   = 1'b1;
                o_cmd.rd_newest = 1'b1;
            end
            wav_pkg::S_LOAD_NEW: o_cmd.start_div = 1'b1;
            wav_pkg::S_DIVIDE:   o_cmd.upd_speed = i_stat.div_done;
            wav_pkg::S_RESULT:   o_cmd.load_out = i_stat.out_free;
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/core/wav_dp.sv
module wav_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic        [wav_pkg::TIME_W-1:0] i_cfg_wr_data,
    input  logic                              i_command,
    input  logic signed [wav_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [wav_pkg::POS_W-1:0]  i_pos_y,
    input  logic        [wav_pkg::TIME_W-1:0] i_elapsed_ms,
    input  logic                              i_out_ready,
    input  wav_pkg::t_cmd                     i_cmd,
    output wav_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    output logic signed [wav_pkg::SPD_W-1:0]  o_speed_x,
    output logic signed [wav_pkg::SPD_W-1:0]  o_speed_y,
    output logic        [wav_pkg::TIME_W-1:0] o_window_time,
    output logic        [wav_pkg::ENT_W-1:0]  o_window_entries,
    output logic                              o_evicted_full
);

    wav_pkg::t_sample                 mem [wav_pkg::DEPTH];
    wav_pkg::t_sample                 r_rd;

    logic [wav_pkg::TIME_W-1:0]       r_span;
    logic [wav_pkg::IDX_W-1:0]        r_oldest;
    logic [wav_pkg::CNT_W-1:0]        r_count;
    logic [wav_pkg::TOT_W-1:0]        r_total;
    logic [wav_pkg::SPD_W-1:0]        r_spd_x;
    logic [wav_pkg::SPD_W-1:0]        r_spd_y;
    logic                             r_evicted;

    logic                             r_cmd;
    logic [wav_pkg::POS_W-1:0]        r_pos_x;
    logic [wav_pkg::POS_W-1:0]        r_pos_y;
    logic [wav_pkg::TIME_W-1:0]       r_ms;
    logic [wav_pkg::POS_W-1:0]        r_old_x;
    logic [wav_pkg::POS_W-1:0]        r_old_y;
    logic                             r_neg_x;
    logic                             r_neg_y;

    logic                             r_out_valid;
    logic [wav_pkg::SPD_W-1:0]        r_out_x;
    logic [wav_pkg::SPD_W-1:0]        r_out_y;
    logic [wav_pkg::TIME_W-1:0]       r_out_time;
    logic [wav_pkg::ENT_W-1:0]        r_out_ent;
    logic                             r_out_evict;

    logic [wav_pkg::SUM_W-1:0]        w_tail_sum;
    logic [wav_pkg::SUM_W-1:0]        w_new_sum;
    logic [wav_pkg::IDX_W-1:0]        w_slot;
    logic [wav_pkg::IDX_W-1:0]        w_newest;
    logic [wav_pkg::IDX_W-1:0]        w_rd_addr;
    logic [wav_pkg::IDX_W-1:0]        n_oldest;
    logic signed [wav_pkg::POS_W:0]   w_dx;
    logic signed [wav_pkg::POS_W:0]   w_dy;
    logic [wav_pkg::POS_W:0]          w_mag_x;
    logic [wav_pkg::POS_W:0]          w_mag_y;
    logic [wav_pkg::QUO_W-1:0]        w_quo_x;
    logic [wav_pkg::QUO_W-1:0]        w_quo_y;
    logic [wav_pkg::SPD_W-1:0]        w_qe_x;
    logic [wav_pkg::SPD_W-1:0]        w_qe_y;
    logic                             w_done_x;
    logic                             w_done_y;

    // circular store addressing
    always_comb begin
        w_tail_sum = wav_pkg::SUM_W'(r_oldest) + wav_pkg::SUM_W'(r_count);
        w_new_sum  = w_tail_sum - wav_pkg::SUM_W'(1);
        w_slot     = (w_tail_sum >= wav_pkg::SUM_W'(wav_pkg::DEPTH))
                   ? wav_pkg::IDX_W'(w_tail_sum - wav_pkg::SUM_W'(wav_pkg::DEPTH))
                   : wav_pkg::IDX_W'(w_tail_sum);
        w_newest   = (w_new_sum >= wav_pkg::SUM_W'(wav_pkg::DEPTH))
                   ? wav_pkg::IDX_W'(w_new_sum - wav_pkg::SUM_W'(wav_pkg::DEPTH))
                   : wav_pkg::IDX_W'(w_new_sum);
        w_rd_addr  = i_cmd.rd_newest ? w_newest : r_oldest;
        n_oldest   = (r_oldest == wav_pkg::IDX_W'(wav_pkg::DEPTH - 1))
                   ? '0 : r_oldest + 1'b1;
    end

    // sample store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_sample) begin
            mem[w_slot] <= '{x: r_pos_x, y: r_pos_y, t: r_ms};
        end
        r_rd <= mem[w_rd_addr];
    end

    // span register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span <= wav_pkg::SPAN_RESET;
        end else if (i_cfg_wr_en) begin
            r_span <= i_cfg_wr_data;
        end
    end

    // window bookkeeping and held speed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest  <= '0;
            r_count   <= '0;
            r_total   <= '0;
            r_spd_x   <= '0;
            r_spd_y   <= '0;
            r_evicted <= 1'b0;
        end else begin
            if (i_cmd.load_item) r_evicted <= 1'b0;
            if (i_cmd.set_evict) r_evicted <= 1'b1;
            if (i_cmd.do_clear) begin
                r_oldest <= '0;
                r_count  <= '0;
                r_total  <= '0;
                r_spd_x  <= '0;
                r_spd_y  <= '0;
            end
            if (i_cmd.drop_oldest) begin
                r_total  <= r_total - wav_pkg::TOT_W'(r_rd.t);
                r_oldest <= n_oldest;
                r_count  <= r_count - 1'b1;
            end
            if (i_cmd.write_sample) begin
                r_total <= r_total + wav_pkg::TOT_W'(r_ms);
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.upd_speed) begin
                r_spd_x <= r_neg_x ? -w_qe_x : w_qe_x;
                r_spd_y <= r_neg_y ? -w_qe_y : w_qe_y;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd   <= i_command;
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_ms    <= i_elapsed_ms;
        end
    end

    // newest minus oldest, sign and magnitude for the dividers
    always_comb begin
        w_dx    = $signed({r_rd.x[wav_pkg::POS_W-1], r_rd.x})
                - $signed({r_old_x[wav_pkg::POS_W-1], r_old_x});
        w_dy    = $signed({r_rd.y[wav_pkg::POS_W-1], r_rd.y})
                - $signed({r_old_y[wav_pkg::POS_W-1], r_old_y});
        w_mag_x = w_dx[wav_pkg::POS_W] ? -w_dx : w_dx;
        w_mag_y = w_dy[wav_pkg::POS_W] ? -w_dy : w_dy;
        w_qe_x  = {1'b0, w_quo_x};
        w_qe_y  = {1'b0, w_quo_y};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_old) begin
            r_old_x <= r_rd.x;
            r_old_y <= r_rd.y;
        end
        if (i_cmd.start_div) begin
            r_neg_x <= w_dx[wav_pkg::POS_W];
            r_neg_y <= w_dy[wav_pkg::POS_W];
        end
    end

    // serial dividers, one per axis, run in lockstep
    wav_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend ({w_mag_x[wav_pkg::POS_W-1:0], {wav_pkg::FRAC_W{1'b0}}}),
        .i_divisor  (r_total),
        .o_quot     (w_quo_x),
        .o_done     (w_done_x)
    );

    wav_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend ({w_mag_y[wav_pkg::POS_W-1:0], {wav_pkg::FRAC_W{1'b0}}}),
        .i_divisor  (r_total),
        .o_quot     (w_quo_y),
        .o_done     (w_done_y)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_x     <= r_spd_x;
            r_out_y     <= r_spd_y;
            r_out_time  <= r_total[wav_pkg::TIME_W-1:0];
            r_out_ent   <= wav_pkg::ENT_W'(r_count);
            r_out_evict <= r_evicted;
        end
    end

    // status to controller
    always_comb begin
        o_stat.is_clear  = (r_cmd == wav_pkg::CMD_CLEAR);
        o_stat.full      = (r_count == wav_pkg::CNT_W'(wav_pkg::DEPTH));
        o_stat.trim_need = (r_total > {1'b0, r_span}) && (r_count != '0);
        o_stat.calc_ok   = (r_count != '0) && (r_total != '0);
        o_stat.div_done  = w_done_x & w_done_y;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid      = r_out_valid;
    assign o_speed_x        = $signed(r_out_x);
    assign o_speed_y        = $signed(r_out_y);
    assign o_window_time    = r_out_time;
    assign o_window_entries = r_out_ent;
    assign o_evicted_full   = r_out_evict;

endmodule

FILE: rtl/core/windowed_average_velocity.sv
// Windowed average velocity over a time-bounded circular window of samples.
// i_in carries requests: command add (a position plus the milliseconds since
// the previous sample) or clear. o_out carries one result per request: signed
// Q16 speed per axis, the window total in ms, the entry count and a flag set
// when a full store pushed out its oldest sample. Both channels move a
// request on a clock edge with valid and ready high. i_cfg_wr_en/i_cfg_wr_data
// write the window span in ms; write it only while the block is idle.
// A clear goes from decode straight to the result. An add evicts the oldest
// sample if the store is full, writes the new one, trims the oldest samples
// while the window total exceeds the span, then runs the 32-step serial
// divider (both axes in parallel); each trimmed sample costs one store read
// and one subtract. An add that leaves the window empty or with zero total
// skips the divide. One request is worked at a time; the next is taken once
// the result sits in the output register, and a stalled receiver holds one
// result while another request is accepted and worked up to its own result.
// Reset empties the window, zeroes the held speed and sets the span to 1000.
module windowed_average_velocity (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [wav_pkg::TIME_W-1:0]   i_cfg_wr_data,
    wav_in_if.sink                       i_in,
    wav_out_if.source                    o_out
);

    wav_pkg::t_cmd  w_cmd;
    wav_pkg::t_stat w_stat;
    logic           w_in_ready;

    // sequencer
    wav_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // window store, arithmetic and output register
    wav_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_command        (i_in.command),
        .i_pos_x          (i_in.pos_x),
        .i_pos_y          (i_in.pos_y),
        .i_elapsed_ms     (i_in.elapsed_ms),
        .i_out_ready      (o_out.ready),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_out_valid      (o_out.valid),
        .o_speed_x        (o_out.speed_x),
        .o_speed_y        (o_out.speed_y),
        .o_window_time    (o_out.window_time),
        .o_window_entries (o_out.window_entries),
        .o_evicted_full   (o_out.evicted_full)
    );

    assign i_in.ready = w_in_ready;

endmodule
